// ===== hw/rtl/status_led_pattern_sequencer_assert.svh =====
// assertion macros used by the checker of the status led pattern sequencer
`ifndef STATUS_LED_PATTERN_SEQUENCER_ASSERT_SVH
`define STATUS_LED_PATTERN_SEQUENCER_ASSERT_SVH

// same-cycle implication
`define SLPS_ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("slps assertion failed");

// next-cycle implication
`define SLPS_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("slps assertion failed");

`endif

// ===== hw/rtl/slps_pkg.sv =====
// types and constants of the status led pattern sequencer
package slps_pkg;

   typedef enum logic [2:0] {
      MODE_INITIAL      = 3'd0,
      MODE_SETUP        = 3'd1,
      MODE_CONNECT      = 3'd2,
      MODE_COMMISSIONED = 3'd3,
      MODE_FACTORY      = 3'd4,
      MODE_RELAY        = 3'd5
   } mode_type;

   typedef enum logic [1:0] {
      NET_NONE         = 2'd0,
      NET_SETUP        = 2'd1,
      NET_CONNECTED    = 2'd2,
      NET_COMMISSIONED = 2'd3
   } net_type;

   typedef enum logic [2:0] {
      CSR_BLINK_PERIOD   = 3'd0,
      CSR_ON_PHASE       = 3'd1,
      CSR_OFF_PHASE      = 3'd2,
      CSR_LONG_DURATION  = 3'd3,
      CSR_SHORT_DURATION = 3'd4
   } csr_index_type;

   localparam logic [6:0]  BLINK_PERIOD_RESET   = 7'd50;
   localparam logic [5:0]  ON_PHASE_RESET       = 6'd26;
   localparam logic [5:0]  OFF_PHASE_RESET      = 6'd1;
   localparam logic [15:0] LONG_DURATION_RESET  = 16'd45000;
   localparam logic [15:0] SHORT_DURATION_RESET = 16'd150;
   localparam logic [6:0]  BLINK_PERIOD_MAX     = 7'd64;

   localparam int CSR_DATA_WIDTH = 16;
   localparam int REQ_DATA_WIDTH = 8;
   localparam int RSP_DATA_WIDTH = 8;

   typedef struct packed {
      logic [6:0]  blink_period;
      logic [5:0]  on_phase;
      logic [5:0]  off_phase;
      logic [15:0] long_duration;
      logic [15:0] short_duration;
   } cfg_type;

   typedef struct packed {
      logic       write_network;
      logic [1:0] network_value;
      logic       write_factory;
      logic       factory_value;
   } req_item_type;

   typedef struct packed {
      logic     green_on;
      logic     red_on;
      mode_type led_mode;
      logic     pattern_done;
   } rsp_item_type;

endpackage

// ===== hw/rtl/status_led_pattern_sequencer.sv =====
// top level of the status led pattern sequencer
//
//   group  direction  word
//   req    in         one tick: network and factory flag writes
//   rsp    out        one result per tick: led drives, mode, done
//   csr    in         register index and write data
//
// one word per clock sustained while rsp is not stalled; a tick's update runs
// from the input register through the core logic into the result register.
// rsp valid rises when a word moves from the input into the result register.
// reset is synchronous; it empties both registers and loads register defaults.
// a stalled rsp holds its word; the input register keeps taking words
// while the result register drains in the same cycle.
module status_led_pattern_sequencer (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // write_network, network_value[1:0], write_factory, factory_value
   input  logic [slps_pkg::REQ_DATA_WIDTH-1:0]  req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // green_on, red_on, led_mode[2:0], pattern_done
   output logic [slps_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  slps_pkg::csr_index_type              csr_index,
   input  logic [slps_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);
   import slps_pkg::*;

   cfg_type      cfg;
   req_item_type in_item_ff, in_item_in;
   logic         in_valid_ff, in_valid_in;
   rsp_item_type rsp_item_ff, rsp_item_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type core_result;
   logic         req_take;
   logic         fire;

   slps_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   slps_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (fire),
      .cfg     (cfg),
      .item    (in_item_ff),
      .result  (core_result)
   );

   assign fire       = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || fire;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      in_item_in = in_item_ff;
      if (req_take) begin
         in_item_in.write_network = req_tdata[0];
         in_item_in.network_value = req_tdata[2:1];
         in_item_in.write_factory = req_tdata[3];
         in_item_in.factory_value = req_tdata[4];
      end
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      rsp_item_in = fire ? core_result : rsp_item_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_item_ff.pattern_done, rsp_item_ff.led_mode,
                        rsp_item_ff.red_on, rsp_item_ff.green_on};

endmodule

// ===== hw/rtl/slps_csr.sv =====
// configuration register file of the status led pattern sequencer
module slps_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  slps_pkg::csr_index_type              csr_index,
   input  logic [slps_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   output slps_pkg::cfg_type                    cfg
);
   import slps_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_BLINK_PERIOD:   cfg_in.blink_period   = csr_wdata[6:0];
            CSR_ON_PHASE:       cfg_in.on_phase       = csr_wdata[5:0];
            CSR_OFF_PHASE:      cfg_in.off_phase      = csr_wdata[5:0];
            CSR_LONG_DURATION:  cfg_in.long_duration  = csr_wdata[15:0];
            CSR_SHORT_DURATION: cfg_in.short_duration = csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.blink_period   <= BLINK_PERIOD_RESET;
         cfg_ff.on_phase       <= ON_PHASE_RESET;
         cfg_ff.off_phase      <= OFF_PHASE_RESET;
         cfg_ff.long_duration  <= LONG_DURATION_RESET;
         cfg_ff.short_duration <= SHORT_DURATION_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== hw/rtl/slps_core.sv =====
// pattern state registers and the per-tick update logic
module slps_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step_en,
   input  slps_pkg::cfg_type      cfg,
   input  slps_pkg::req_item_type item,
   output slps_pkg::rsp_item_type result
);
   import slps_pkg::*;

   logic [1:0]  latched_ff, latched_in;
   logic [1:0]  seen_ff, seen_in;
   mode_type    mode_ff, mode_in;
   mode_type    prev_ff, prev_in;
   logic [15:0] tick_ff, tick_in;
   logic [5:0]  phase_ff, phase_in;
   logic        done_ff, done_in;
   logic        factory_ff, factory_in;
   logic        green_ff, green_in;
   logic        red_ff, red_in;

   logic [6:0]  period_lim;
   logic [6:0]  phase_next;
   logic        finish;

   always_comb begin
      if (cfg.blink_period == 7'd0) begin
         period_lim = 7'd1;
      end else if (cfg.blink_period > BLINK_PERIOD_MAX) begin
         period_lim = BLINK_PERIOD_MAX;
      end else begin
         period_lim = cfg.blink_period;
      end
      phase_next = {1'b0, phase_ff} + 7'd1;
   end

   always_comb begin
      latched_in = item.write_network ? item.network_value : latched_ff;
      factory_in = item.write_factory ? item.factory_value : factory_ff;
      seen_in    = latched_in;
      mode_in    = mode_ff;

      // mode pick from a newly latched network state
      if (seen_ff != latched_in) begin
         unique case (net_type'(latched_in))
            NET_SETUP:        mode_in = MODE_SETUP;
            NET_CONNECTED:    mode_in = MODE_CONNECT;
            NET_COMMISSIONED: mode_in = MODE_COMMISSIONED;
            default: ;
         endcase
      end
      if (factory_in) begin
         mode_in = MODE_FACTORY;
      end
      if (done_ff) begin
         mode_in = MODE_RELAY;
      end

      prev_in  = mode_in;
      done_in  = done_ff;
      tick_in  = tick_ff;
      phase_in = phase_ff;
      if (prev_ff != mode_in) begin
         done_in  = 1'b0;
         tick_in  = '0;
         phase_in = '0;
      end else if (tick_ff < cfg.long_duration) begin
         tick_in  = tick_ff + 16'd1;
         phase_in = (phase_next >= period_lim) ? 6'd0 : phase_next[5:0];
      end

      green_in = green_ff;
      red_in   = red_ff;
      finish   = 1'b0;
      unique case (mode_in)
         MODE_SETUP: begin
            if (phase_in == cfg.on_phase) begin
               green_in = 1'b1;
               red_in   = 1'b0;
            end else if (phase_in == cfg.off_phase) begin
               green_in = 1'b0;
               red_in   = 1'b0;
            end
            finish = (tick_in == cfg.long_duration);
         end
         MODE_CONNECT, MODE_COMMISSIONED: begin
            if (tick_in == 16'd1) begin
               green_in = 1'b1;
               red_in   = (mode_in == MODE_COMMISSIONED);
            end else if (tick_in == cfg.short_duration) begin
               finish = 1'b1;
            end
         end
         MODE_FACTORY: begin
            if (phase_in == cfg.on_phase) begin
               green_in = 1'b1;
               red_in   = 1'b0;
            end else if (phase_in == cfg.off_phase) begin
               green_in = 1'b0;
               red_in   = 1'b1;
            end
         end
         default: ;
      endcase

      // pattern end: leds off, latched state cleared
      if (finish) begin
         green_in   = 1'b0;
         red_in     = 1'b0;
         done_in    = 1'b1;
         seen_in    = '0;
         mode_in    = MODE_INITIAL;
         prev_in    = MODE_INITIAL;
         latched_in = '0;
         factory_in = 1'b0;
      end
   end

   assign result.green_on     = green_in;
   assign result.red_on       = red_in;
   assign result.led_mode     = mode_in;
   assign result.pattern_done = done_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         latched_ff <= '0;
         seen_ff    <= '0;
         mode_ff    <= MODE_INITIAL;
         prev_ff    <= MODE_INITIAL;
         tick_ff    <= '0;
         phase_ff   <= '0;
         done_ff    <= 1'b0;
         factory_ff <= 1'b0;
         green_ff   <= 1'b0;
         red_ff     <= 1'b0;
      end else if (step_en) begin
         latched_ff <= latched_in;
         seen_ff    <= seen_in;
         mode_ff    <= mode_in;
         prev_ff    <= prev_in;
         tick_ff    <= tick_in;
         phase_ff   <= phase_in;
         done_ff    <= done_in;
         factory_ff <= factory_in;
         green_ff   <= green_in;
         red_ff     <= red_in;
      end
   end

endmodule

// ===== hw/rtl/slps_checker.sv =====
// port checker of the status led pattern sequencer and its bind
`include "status_led_pattern_sequencer_assert.svh"

module slps_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [slps_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata
);
   import slps_pkg::*;

   // a stalled result word holds
   `SLPS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // done only on the finishing tick: leds off and mode back to initial
   `SLPS_ASSERT_IMPLY(a_done_clean, clock, reset, rsp_tvalid && rsp_tdata[5], rsp_tdata[1:0] == 2'b00 && rsp_tdata[4:2] == MODE_INITIAL)

   // nothing comes out right after reset
   `SLPS_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid)

   // with an empty result register the input side never stalls
   `SLPS_ASSERT_IMPLY(a_req_free, clock, reset, !rsp_tvalid, req_tready)

endmodule

bind status_led_pattern_sequencer slps_checker u_slps_checker (.*);
